/* hdl/qte_pkg.sv */
package qte_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int STEPS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    localparam int NORM_STAGES = 6;
    localparam int IN_W = 36;
    localparam int CORD_W = 46;
    localparam int ACC_W = 29;
    localparam int ANG_W = 19;
    localparam int ROOT_W = 29;
    localparam int RAD_W = 57;
    localparam int REM_W = 60;
    localparam int SQRT_STAGES = ROOT_W;

    localparam logic signed [ACC_W-1:0] ANG_PI = 29'sd52707179;
    localparam logic signed [ANG_W-1:0] OUT_PI = 19'sd25736;
    localparam logic signed [ANG_W-1:0] OUT_HALF_PI = 19'sd12868;
    localparam logic signed [35:0] ONE_Q28 = 36'sd268435456;

    typedef struct packed {
        logic signed [29:0]     s;
        logic signed [IN_W-1:0] yaw_y;
        logic signed [IN_W-1:0] yaw_x;
        logic signed [IN_W-1:0] roll_y;
        logic signed [IN_W-1:0] roll_x;
    } qte_side_t;

    function automatic logic [23:0] arc_step(input int i);
        logic [23:0] v;
        unique case (i)
            0: v = 24'd13176795;
            1: v = 24'd7778716;
            2: v = 24'd4110060;
            3: v = 24'd2086331;
            4: v = 24'd1047214;
            5: v = 24'd524117;
            6: v = 24'd262123;
            7: v = 24'd131069;
            8: v = 24'd65536;
            9: v = 24'd32768;
            10: v = 24'd16384;
            11: v = 24'd8192;
            12: v = 24'd4096;
            13: v = 24'd2048;
            14: v = 24'd1024;
            15: v = 24'd512;
            16: v = 24'd256;
            17: v = 24'd128;
            18: v = 24'd64;
            19: v = 24'd32;
            20: v = 24'd16;
            21: v = 24'd8;
            22: v = 24'd4;
            23: v = 24'd2;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

/* hdl/qte_in_if.sv */
interface qte_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;

    modport source(output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink(input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

/* hdl/qte_out_if.sv */
interface qte_out_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] roll_angle;

    modport source(output valid, pitch_angle, yaw_angle, roll_angle, input ready);
    modport sink(input valid, pitch_angle, yaw_angle, roll_angle, output ready);
endinterface

/* hdl/quaternion_to_euler_angles.sv */
// Quaternion to Euler angle converter.
// The quat_in channel takes one quaternion (w, x, y, z), signed Q2.14, per
// transaction. The euler_out channel returns one transaction per input with
// pitch, yaw and roll in radians, signed Q3.13 (pitch Q2.13); pitch lies within +-pi/2 and
// yaw and roll within +-pi. Unnormalized input is tolerated: the asin
// argument is clamped to +-1, and atan2 of two zero operands gives zero.
// The datapath is a single pipeline: three stages of products and sums, one
// stage per bit of the 29-bit square root that feeds the pitch atan2, then
// three parallel CORDIC units with a fold stage, six normalizing stages and
// one stage per rotation, and a final output register. A new transaction
// is accepted every cycle while the output is not stalled.
// Reset clears all valid bits, so the pipeline comes up empty.
// When the receiver holds ready low while a result is waiting, the whole
// pipeline freezes and quat_in.ready drops; nothing is lost or repeated, and
// the output holds steady until it is taken.
module quaternion_to_euler_angles (
    input  logic      clk,
    input  logic      rst_n,
    qte_in_if.sink    quat_in,
    qte_out_if.source euler_out
);
    import qte_pkg::*;

    // One enable for every stage: advance unless a result is stuck at the output.
    logic en;

    logic              front_valid;
    logic [RAD_W-1:0]  radicand;
    qte_side_t         front_side;

    logic              sqrt_valid;
    logic [ROOT_W-1:0] root;
    qte_side_t         sqrt_side;

    logic                    pitch_valid, yaw_valid, roll_valid;
    logic signed [ANG_W-1:0] pitch_raw, yaw_raw, roll_raw;

    logic               out_valid_reg;
    logic signed [14:0] pitch_reg, pitch_next;
    logic signed [15:0] yaw_reg, yaw_next;
    logic signed [15:0] roll_reg, roll_next;

    assign en            = !out_valid_reg || euler_out.ready;
    assign quat_in.ready = en;

    qte_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (quat_in.valid),
        .qw        (quat_in.quat_w),
        .qx        (quat_in.quat_x),
        .qy        (quat_in.quat_y),
        .qz        (quat_in.quat_z),
        .out_valid (front_valid),
        .radicand  (radicand),
        .side      (front_side)
    );

    qte_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .radicand  (radicand),
        .side_in   (front_side),
        .out_valid (sqrt_valid),
        .root      (root),
        .side_out  (sqrt_side)
    );

    // Pitch is asin(s), taken as atan2(s, sqrt(1 - s^2)).
    qte_cordic u_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sqrt_valid),
        .op_y      (IN_W'(sqrt_side.s)),
        .op_x      (IN_W'(root)),
        .out_valid (pitch_valid),
        .angle     (pitch_raw)
    );

    qte_cordic u_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sqrt_valid),
        .op_y      (sqrt_side.yaw_y),
        .op_x      (sqrt_side.yaw_x),
        .out_valid (yaw_valid),
        .angle     (yaw_raw)
    );

    qte_cordic u_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sqrt_valid),
        .op_y      (sqrt_side.roll_y),
        .op_x      (sqrt_side.roll_x),
        .out_valid (roll_valid),
        .angle     (roll_raw)
    );

    // Final range clamp before the output register.
    always_comb
    begin
        if (pitch_raw > OUT_HALF_PI)
            pitch_next = 15'(OUT_HALF_PI);
        else if (pitch_raw < -OUT_HALF_PI)
            pitch_next = 15'(-OUT_HALF_PI);
        else
            pitch_next = 15'(pitch_raw);

        if (yaw_raw > OUT_PI)
            yaw_next = 16'(OUT_PI);
        else if (yaw_raw < -OUT_PI)
            yaw_next = 16'(-OUT_PI);
        else
            yaw_next = 16'(yaw_raw);

        if (roll_raw > OUT_PI)
            roll_next = 16'(OUT_PI);
        else if (roll_raw < -OUT_PI)
            roll_next = 16'(-OUT_PI);
        else
            roll_next = 16'(roll_raw);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= pitch_valid && yaw_valid && roll_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pitch_reg <= pitch_next;
            yaw_reg   <= yaw_next;
            roll_reg  <= roll_next;
        end
    end

    assign euler_out.valid       = out_valid_reg;
    assign euler_out.pitch_angle = pitch_reg;
    assign euler_out.yaw_angle   = yaw_reg;
    assign euler_out.roll_angle  = roll_reg;
endmodule

/* hdl/qte_front.sv */
module qte_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic signed [15:0]         qw,
    input  logic signed [15:0]         qx,
    input  logic signed [15:0]         qy,
    input  logic signed [15:0]         qz,
    output logic                       out_valid,
    output logic [qte_pkg::RAD_W-1:0]  radicand,
    output qte_pkg::qte_side_t         side
);
    import qte_pkg::*;

    logic               v1_reg, v2_reg, v3_reg;
    logic signed [31:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [31:0] wx_reg, yz_reg, xz_reg, wy_reg, xy_reg, wz_reg;
    qte_side_t          side2_reg, side2_next, side3_reg;
    logic [RAD_W-1:0]   rad_reg, rad_next;
    logic signed [35:0] pd;
    logic signed [59:0] sq;

    // Stage two: sums of products, asin argument clamped to +-1.
    always_comb
    begin
        pd = (36'(wx_reg) - 36'(yz_reg)) <<< 1;
        if (pd > ONE_Q28)
            side2_next.s = 30'(ONE_Q28);
        else if (pd < -ONE_Q28)
            side2_next.s = 30'(-ONE_Q28);
        else
            side2_next.s = 30'(pd);
        side2_next.yaw_y  = (36'(xz_reg) + 36'(wy_reg)) <<< 1;
        side2_next.yaw_x  = 36'(ww_reg) - 36'(xx_reg) - 36'(yy_reg) + 36'(zz_reg);
        side2_next.roll_y = (36'(xy_reg) + 36'(wz_reg)) <<< 1;
        side2_next.roll_x = 36'(ww_reg) - 36'(xx_reg) + 36'(yy_reg) - 36'(zz_reg);
    end

    // Stage three: radicand 1 - s^2 at 2^-56 scale.
    always_comb
    begin
        sq = 60'(side2_reg.s) * 60'(side2_reg.s);
        rad_next = (57'd1 << 56) - 57'(sq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ww_reg <= qw * qw;
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            zz_reg <= qz * qz;
            wx_reg <= qw * qx;
            yz_reg <= qy * qz;
            xz_reg <= qx * qz;
            wy_reg <= qw * qy;
            xy_reg <= qx * qy;
            wz_reg <= qw * qz;
            side2_reg <= side2_next;
            side3_reg <= side2_reg;
            rad_reg <= rad_next;
        end
    end

    assign out_valid = v3_reg;
    assign radicand  = rad_reg;
    assign side      = side3_reg;
endmodule

/* hdl/qte_isqrt.sv */
module qte_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [qte_pkg::RAD_W-1:0]   radicand,
    input  qte_pkg::qte_side_t          side_in,
    output logic                        out_valid,
    output logic [qte_pkg::ROOT_W-1:0]  root,
    output qte_pkg::qte_side_t          side_out
);
    import qte_pkg::*;

    logic              v_reg    [0:SQRT_STAGES];
    logic [REM_W-1:0]  rem_reg  [0:SQRT_STAGES];
    logic [ROOT_W-1:0] root_reg [0:SQRT_STAGES];
    qte_side_t         side_reg [0:SQRT_STAGES];

    always_comb
    begin
        v_reg[0]    = in_valid;
        rem_reg[0]  = REM_W'(radicand);
        root_reg[0] = '0;
        side_reg[0] = side_in;
    end

    // One root bit per stage, most significant first.
    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_bit
        localparam int B = SQRT_STAGES - 1 - k;
        logic [REM_W-1:0] trial;
        logic             take;

        always_comb
        begin
            trial = (REM_W'(root_reg[k]) << (B + 1)) + (REM_W'(1) << (2 * B));
            take  = rem_reg[k] >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else if (en)
                v_reg[k+1] <= v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= take ? rem_reg[k] - trial : rem_reg[k];
                root_reg[k+1] <= take ? root_reg[k] | (ROOT_W'(1) << B) : root_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = v_reg[SQRT_STAGES];
    assign root      = root_reg[SQRT_STAGES];
    assign side_out  = side_reg[SQRT_STAGES];
endmodule

/* hdl/qte_cordic.sv */
module qte_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [qte_pkg::IN_W-1:0]   op_y,
    input  logic signed [qte_pkg::IN_W-1:0]   op_x,
    output logic                              out_valid,
    output logic signed [qte_pkg::ANG_W-1:0]  angle
);
    import qte_pkg::*;

    localparam int LAST = NORM_STAGES + STEPS;

    logic                     v_reg   [0:LAST];
    logic                     z_reg   [0:LAST];
    logic signed [CORD_W-1:0] x_reg   [0:LAST];
    logic signed [CORD_W-1:0] y_reg   [0:LAST];
    logic signed [ACC_W-1:0]  acc_reg [0:LAST];
    logic signed [ACC_W:0]    rounded;

    // Entry stage: fold the left half plane onto the right one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg[0] <= (op_x == '0) && (op_y == '0);
            if (op_x < 0)
            begin
                x_reg[0]   <= -CORD_W'(op_x);
                y_reg[0]   <= -CORD_W'(op_y);
                acc_reg[0] <= (op_y >= 0) ? ANG_PI : -ANG_PI;
            end
            else
            begin
                x_reg[0]   <= CORD_W'(op_x);
                y_reg[0]   <= CORD_W'(op_y);
                acc_reg[0] <= '0;
            end
        end
    end

    for (genvar j = 1; j <= LAST; j++)
    begin : g_stage
        logic signed [CORD_W-1:0] x_n, y_n;
        logic signed [ACC_W-1:0]  acc_n;

        if (j <= NORM_STAGES)
        begin : g_norm
            // Binary search for the doubling count that lifts the larger
            // magnitude into [2^40, 2^41).
            localparam int SH = 1 << (NORM_STAGES - j);
            logic [CORD_W-1:0] m;
            always_comb
            begin
                m = CORD_W'(x_reg[j-1]) | CORD_W'(y_reg[j-1] < 0 ? -y_reg[j-1] : y_reg[j-1]);
                if (m < (CORD_W'(1) << (41 - SH)))
                begin
                    x_n = x_reg[j-1] <<< SH;
                    y_n = y_reg[j-1] <<< SH;
                end
                else
                begin
                    x_n = x_reg[j-1];
                    y_n = y_reg[j-1];
                end
                acc_n = acc_reg[j-1];
            end
        end
        else
        begin : g_iter
            localparam int I = j - NORM_STAGES - 1;
            localparam logic signed [ACC_W-1:0] ARC = ACC_W'(arc_step(I));
            always_comb
            begin
                if (y_reg[j-1] < 0)
                begin
                    x_n   = x_reg[j-1] - (y_reg[j-1] >>> I);
                    y_n   = y_reg[j-1] + (x_reg[j-1] >>> I);
                    acc_n = acc_reg[j-1] - ARC;
                end
                else
                begin
                    x_n   = x_reg[j-1] + (y_reg[j-1] >>> I);
                    y_n   = y_reg[j-1] - (x_reg[j-1] >>> I);
                    acc_n = acc_reg[j-1] + ARC;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else if (en)
                v_reg[j] <= v_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                z_reg[j]   <= z_reg[j-1];
                x_reg[j]   <= x_n;
                y_reg[j]   <= y_n;
                acc_reg[j] <= acc_n;
            end
        end
    end

    always_comb
    begin
        rounded = (ACC_W+1)'(acc_reg[LAST]) + (ACC_W+1)'(1024);
        angle   = z_reg[LAST] ? '0 : ANG_W'(rounded >>> 11);
    end

    assign out_valid = v_reg[LAST];
endmodule
